// ===== rtl/core/box_iou_defines.svh =====
// assertion macros for the box iou block
// no dependencies; included by files that carry concurrent checks
`ifndef BOX_IOU_DEFINES_SVH
`define BOX_IOU_DEFINES_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define BIOU_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// condition must never be seen outside reset
`define BIOU_ASSERT_NEVER(name, clk, rstn, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define BIOU_ASSERT(name, clk, rstn, prop, msg)
`define BIOU_ASSERT_NEVER(name, clk, rstn, cond, msg)
`endif

`endif

// ===== rtl/core/biou_pkg.sv =====
// shared constants and types for the box iou pipeline
// no dependencies
`timescale 1ns / 1ps

package biou_pkg;

    // default coordinate width in bits
    localparam int COORD_BITS_DEF = 16;

    // fraction bits of the ratio and its full width (covers 1.0)
    localparam int FRAC_BITS  = 16;
    localparam int RATIO_BITS = FRAC_BITS + 1;

    // ratio code for 1.0
    localparam logic [RATIO_BITS-1:0] RATIO_ONE = RATIO_BITS'(1) << FRAC_BITS;

    // per-stage tag that travels with each beat
    typedef struct packed {
        logic valid;
        logic union_zero;
    } t_beat_tag;

endpackage

// ===== rtl/core/biou_if.sv =====
// valid/ready channel interfaces for box pairs and iou results
// depends on biou_pkg
`timescale 1ns / 1ps

interface biou_in_if #(
    parameter int COORD_BITS = biou_pkg::COORD_BITS_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] first_xmin;
    logic signed [COORD_BITS-1:0] first_ymin;
    logic signed [COORD_BITS-1:0] first_xmax;
    logic signed [COORD_BITS-1:0] first_ymax;
    logic signed [COORD_BITS-1:0] second_xmin;
    logic signed [COORD_BITS-1:0] second_ymin;
    logic signed [COORD_BITS-1:0] second_xmax;
    logic signed [COORD_BITS-1:0] second_ymax;

    modport source (
        output valid, first_xmin, first_ymin, first_xmax, first_ymax,
               second_xmin, second_ymin, second_xmax, second_ymax,
        input  ready
    );
    modport sink (
        input  valid, first_xmin, first_ymin, first_xmax, first_ymax,
               second_xmin, second_ymin, second_xmax, second_ymax,
        output ready
    );
endinterface

interface biou_out_if #(
    parameter int COORD_BITS = biou_pkg::COORD_BITS_DEF
) ();
    logic                              valid;
    logic                              ready;
    logic [biou_pkg::RATIO_BITS-1:0]   ratio;
    logic [2*COORD_BITS-1:0]           overlap_area;
    logic [2*COORD_BITS:0]             union_area;
    logic                              union_zero;

    modport source (
        output valid, ratio, overlap_area, union_area, union_zero,
        input  ready
    );
    modport sink (
        input  valid, ratio, overlap_area, union_area, union_zero,
        output ready
    );
endinterface

// ===== rtl/core/biou_geom.sv =====
// geometry front end: overlap corners, clamped spans, areas, union
// four register stages; depends on biou_pkg
`timescale 1ns / 1ps

module biou_geom #(
    parameter int COORD_BITS = biou_pkg::COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic                          i_valid,
    input  logic signed [COORD_BITS-1:0]  i_first  [4],
    input  logic signed [COORD_BITS-1:0]  i_second [4],
    output biou_pkg::t_beat_tag           o_tag,
    output logic [2*COORD_BITS-1:0]       o_overlap,
    output logic [2*COORD_BITS:0]         o_union
);

    localparam int AW = 2 * COORD_BITS;
    localparam int UW = AW + 1;

    // clamped span: hi - lo when positive, else zero
    function automatic logic [COORD_BITS-1:0] f_span(
        input logic signed [COORD_BITS-1:0] lo,
        input logic signed [COORD_BITS-1:0] hi
    );
        logic signed [COORD_BITS:0] diff;
        diff = COORD_BITS'(1) == 0 ? '0 : ($signed({hi[COORD_BITS-1], hi})
                                          - $signed({lo[COORD_BITS-1], lo}));
        return diff[COORD_BITS] ? '0 : diff[COORD_BITS-1:0];
    endfunction

    logic                         r1_valid, r2_valid, r3_valid, r4_valid;
    logic signed [COORD_BITS-1:0] r1_a [4];
    logic signed [COORD_BITS-1:0] r1_b [4];
    logic signed [COORD_BITS-1:0] r1_i [4];
    logic signed [COORD_BITS-1:0] n1_i [4];
    logic [COORD_BITS-1:0]        r2_span_a [2];
    logic [COORD_BITS-1:0]        r2_span_b [2];
    logic [COORD_BITS-1:0]        r2_span_i [2];
    logic [AW-1:0]                r3_area_a, r3_area_b, r3_area_i;
    logic [AW-1:0]                n3_area_a, n3_area_b, n3_area_i;
    logic [AW-1:0]                r4_overlap;
    logic [UW-1:0]                r4_union;
    logic [UW-1:0]                n4_union;
    logic                         r4_zero;

    // stage 1: overlap box corners, larger min and smaller max per axis
    always_comb begin
        n1_i[0] = (i_first[0] > i_second[0]) ? i_first[0] : i_second[0];
        n1_i[1] = (i_first[1] > i_second[1]) ? i_first[1] : i_second[1];
        n1_i[2] = (i_first[2] < i_second[2]) ? i_first[2] : i_second[2];
        n1_i[3] = (i_first[3] < i_second[3]) ? i_first[3] : i_second[3];
    end

    // stage 3: one multiplier per area
    always_comb begin
        n3_area_a = AW'(r2_span_a[0]) * AW'(r2_span_a[1]);
        n3_area_b = AW'(r2_span_b[0]) * AW'(r2_span_b[1]);
        n3_area_i = AW'(r2_span_i[0]) * AW'(r2_span_i[1]);
    end

    // stage 4: union, never negative since overlap fits in either box
    assign n4_union = UW'(r3_area_a) + UW'(r3_area_b) - UW'(r3_area_i);

    // valid bits of the four stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else if (i_adv) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
    end

    // payload registers of the four stages
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_a         <= i_first;
            r1_b         <= i_second;
            r1_i         <= n1_i;
            r2_span_a[0] <= f_span(r1_a[0], r1_a[2]);
            r2_span_a[1] <= f_span(r1_a[1], r1_a[3]);
            r2_span_b[0] <= f_span(r1_b[0], r1_b[2]);
            r2_span_b[1] <= f_span(r1_b[1], r1_b[3]);
            r2_span_i[0] <= f_span(r1_i[0], r1_i[2]);
            r2_span_i[1] <= f_span(r1_i[1], r1_i[3]);
            r3_area_a    <= n3_area_a;
            r3_area_b    <= n3_area_b;
            r3_area_i    <= n3_area_i;
            r4_overlap   <= r3_area_i;
            r4_union     <= n4_union;
            r4_zero      <= (r3_area_a == '0) && (r3_area_b == '0);
        end
    end

    assign o_tag.valid      = r4_valid;
    assign o_tag.union_zero = r4_zero;
    assign o_overlap        = r4_overlap;
    assign o_union          = r4_union;

endmodule

// ===== rtl/core/biou_div.sv =====
// pipelined restoring divider: one quotient bit per stage
// computes floor(overlap * 2^FRAC_BITS / union); depends on biou_pkg
`timescale 1ns / 1ps

module biou_div #(
    parameter int COORD_BITS = biou_pkg::COORD_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_adv,
    input  biou_pkg::t_beat_tag              i_tag,
    input  logic [2*COORD_BITS-1:0]          i_overlap,
    input  logic [2*COORD_BITS:0]            i_union,
    output biou_pkg::t_beat_tag              o_tag,
    output logic [biou_pkg::RATIO_BITS-1:0]  o_quotient,
    output logic [2*COORD_BITS-1:0]          o_overlap,
    output logic [2*COORD_BITS:0]            o_union
);

    localparam int AW = 2 * COORD_BITS;
    localparam int UW = AW + 1;
    localparam int NS = biou_pkg::RATIO_BITS;

    logic [NS-1:0] r_valid;
    logic [NS-1:0] r_zero;
    logic [UW-1:0] r_rem  [NS];
    logic [UW-1:0] r_den  [NS];
    logic [AW-1:0] r_ov   [NS];
    logic [NS-1:0] r_quo  [NS];

    logic [NS-1:0] w_pv_valid;
    logic [NS-1:0] w_pv_zero;
    logic [UW-1:0] w_pv_rem [NS];
    logic [UW-1:0] w_pv_den [NS];
    logic [AW-1:0] w_pv_ov  [NS];
    logic [NS-1:0] w_pv_quo [NS];
    logic [UW-1:0] n_rem    [NS];
    logic [NS-1:0] n_quo    [NS];

    // inputs of each stage: the divider inputs or the previous stage
    always_comb begin
        w_pv_valid[0] = i_tag.valid;
        w_pv_zero[0]  = i_tag.union_zero;
        w_pv_rem[0]   = UW'(i_overlap);
        w_pv_den[0]   = i_union;
        w_pv_ov[0]    = i_overlap;
        w_pv_quo[0]   = '0;
        for (int s = 1; s < NS; s++) begin
            w_pv_valid[s] = r_valid[s-1];
            w_pv_zero[s]  = r_zero[s-1];
            w_pv_rem[s]   = r_rem[s-1];
            w_pv_den[s]   = r_den[s-1];
            w_pv_ov[s]    = r_ov[s-1];
            w_pv_quo[s]   = r_quo[s-1];
        end
    end

    // trial subtract per stage; the first stage weighs 2^FRAC_BITS unshifted
    always_comb begin
        logic [UW:0]   trial;
        logic [UW+1:0] diff;
        logic          qbit;
        for (int s = 0; s < NS; s++) begin
            trial = (s == 0) ? {1'b0, w_pv_rem[s]} : {w_pv_rem[s], 1'b0};
            diff  = {1'b0, trial} - {2'b00, w_pv_den[s]};
            qbit  = ~diff[UW+1];
            n_rem[s] = qbit ? diff[UW-1:0] : trial[UW-1:0];
            n_quo[s] = {w_pv_quo[s][NS-2:0], qbit};
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_adv) begin
            r_valid <= w_pv_valid;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_zero <= w_pv_zero;
            for (int s = 0; s < NS; s++) begin
                r_rem[s] <= n_rem[s];
                r_den[s] <= w_pv_den[s];
                r_ov[s]  <= w_pv_ov[s];
                r_quo[s] <= n_quo[s];
            end
        end
    end

    assign o_tag.valid      = r_valid[NS-1];
    assign o_tag.union_zero = r_zero[NS-1];
    assign o_quotient       = r_quo[NS-1];
    assign o_overlap        = r_ov[NS-1];
    assign o_union          = r_den[NS-1];

endmodule

// ===== rtl/core/biou_skid.sv =====
// output register with one skid entry
// upstream ready is registered; no dependencies
`timescale 1ns / 1ps

module biou_skid #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_up_valid,
    output logic             o_up_ready,
    input  logic [WIDTH-1:0] i_up_data,
    output logic             o_dn_valid,
    input  logic             i_dn_ready,
    output logic [WIDTH-1:0] o_dn_data
);

    logic             r_out_valid;
    logic             r_skid_valid;
    logic [WIDTH-1:0] r_out_data;
    logic [WIDTH-1:0] r_skid_data;

    // control: the skid entry fills only when the output register is stuck
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (i_dn_ready) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_up_valid) begin
            if (!r_out_valid || i_dn_ready) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (i_dn_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // data
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (i_dn_ready) begin
                r_out_data <= r_skid_data;
            end
        end else if (i_up_valid) begin
            if (!r_out_valid || i_dn_ready) begin
                r_out_data <= i_up_data;
            end else begin
                r_skid_data <= i_up_data;
            end
        end
    end

    assign o_up_ready = ~r_skid_valid;
    assign o_dn_valid = r_out_valid;
    assign o_dn_data  = r_out_data;

endmodule

// ===== rtl/core/box_iou.sv =====
// box iou top level: geometry stages, divider pipeline, output skid
// depends on biou_pkg, biou_if, biou_geom, biou_div, biou_skid, box_iou_defines.svh
//
//   port    dir  beat contents
//   i_box   in   two boxes, eight signed corner coordinates
//   o_res   out  ratio, overlap_area, union_area, union_zero
//
// one box pair per cycle sustained while o_res takes results; a pair's result passes
// 4 geometry stages, 17 divider stages at one quotient bit each, and the output register.
// reset clears all valid bits and the skid entry; payload registers are not reset.
// a stall on o_res freezes the whole pipeline once a further beat arrives: the skid entry
// takes the beat in flight, and i_box.ready (registered) drops until it drains.
`timescale 1ns / 1ps
`include "box_iou_defines.svh"

module box_iou #(
    parameter int COORD_BITS = biou_pkg::COORD_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    biou_in_if.sink       i_box,
    biou_out_if.source    o_res
);

    localparam int AW = 2 * COORD_BITS;
    localparam int UW = AW + 1;
    localparam int RW = biou_pkg::RATIO_BITS;
    localparam int DW = RW + AW + UW + 1;

    logic                         w_adv;
    logic signed [COORD_BITS-1:0] w_first  [4];
    logic signed [COORD_BITS-1:0] w_second [4];
    biou_pkg::t_beat_tag          w_geom_tag;
    logic [AW-1:0]                w_geom_ov;
    logic [UW-1:0]                w_geom_un;
    biou_pkg::t_beat_tag          w_div_tag;
    logic [RW-1:0]                w_div_quo;
    logic [AW-1:0]                w_div_ov;
    logic [UW-1:0]                w_div_un;
    logic [RW-1:0]                w_ratio;
    logic [DW-1:0]                w_up_data;
    logic [DW-1:0]                w_dn_data;

    // input beat unpacking
    assign w_first[0]  = i_box.first_xmin;
    assign w_first[1]  = i_box.first_ymin;
    assign w_first[2]  = i_box.first_xmax;
    assign w_first[3]  = i_box.first_ymax;
    assign w_second[0] = i_box.second_xmin;
    assign w_second[1] = i_box.second_ymin;
    assign w_second[2] = i_box.second_xmax;
    assign w_second[3] = i_box.second_ymax;
    assign i_box.ready = w_adv;

    biou_geom #(.COORD_BITS(COORD_BITS)) u_geom (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (w_adv),
        .i_valid   (i_box.valid),
        .i_first   (w_first),
        .i_second  (w_second),
        .o_tag     (w_geom_tag),
        .o_overlap (w_geom_ov),
        .o_union   (w_geom_un)
    );

    biou_div #(.COORD_BITS(COORD_BITS)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (w_adv),
        .i_tag      (w_geom_tag),
        .i_overlap  (w_geom_ov),
        .i_union    (w_geom_un),
        .o_tag      (w_div_tag),
        .o_quotient (w_div_quo),
        .o_overlap  (w_div_ov),
        .o_union    (w_div_un)
    );

    // empty union gives a ratio of zero
    assign w_ratio   = w_div_tag.union_zero ? '0 : w_div_quo;
    assign w_up_data = {w_ratio, w_div_ov, w_div_un, w_div_tag.union_zero};

    biou_skid #(.WIDTH(DW)) u_skid (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_up_valid (w_div_tag.valid),
        .o_up_ready (w_adv),
        .i_up_data  (w_up_data),
        .o_dn_valid (o_res.valid),
        .i_dn_ready (o_res.ready),
        .o_dn_data  (w_dn_data)
    );

    // output beat packing
    assign o_res.ratio        = w_dn_data[DW-1 -: RW];
    assign o_res.overlap_area = w_dn_data[UW+AW -: AW];
    assign o_res.union_area   = w_dn_data[UW -: UW];
    assign o_res.union_zero   = w_dn_data[0];

    // checks
    `BIOU_ASSERT(a_zero_union_clean, i_clk, i_rst_n, o_res.valid && o_res.union_zero |-> o_res.ratio == '0 && o_res.overlap_area == '0, "empty union with nonzero ratio or overlap")
    `BIOU_ASSERT_NEVER(a_ratio_range, i_clk, i_rst_n, o_res.valid && (o_res.ratio > biou_pkg::RATIO_ONE), "ratio above one")
    `BIOU_ASSERT_NEVER(a_overlap_le_union, i_clk, i_rst_n, o_res.valid && ({1'b0, o_res.overlap_area} > o_res.union_area), "overlap exceeds union")
    `BIOU_ASSERT(a_stall_needs_result, i_clk, i_rst_n, !w_adv |-> o_res.valid, "pipeline frozen with no result pending")

endmodule
